/* sv/text_console_writer_assert.svh */
// Assertion macros shared by the console writer checker.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TCW_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tcw_checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is high.
`define TCW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tcw_checker: next-cycle property failed");

`endif

/* sv/tcw_pkg.sv */
// Shared constants and types of the text console writer.
// No dependencies; used by the video memory, the top level and the checker.
`default_nettype none

package tcw_pkg;

   // Default geometry of the console and its video memory.
   localparam int VIDEO_WORDS_DEF = 8192;
   localparam int LINE_CHARS_DEF  = 80;
   localparam int SCREEN_ROWS_DEF = 25;

   // Port field widths.
   localparam int WORD_W = 16;
   localparam int ADDR_W = 13;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int OP_W   = 2;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [OP_W-1:0]   op_type;
   typedef logic [CHAR_W-1:0] char_type;

   // Operation codes.
   localparam op_type OP_PUT    = 2'd0;
   localparam op_type OP_SETPOS = 2'd1;
   localparam op_type OP_READ   = 2'd2;

   // Control characters.
   localparam char_type CH_BACKSPACE = 8'h08;
   localparam char_type CH_NEWLINE   = 8'h0A;
   localparam char_type CH_RETURN    = 8'h0D;

   // Fill words and register reset.
   localparam word_type BLANK_WORD   = 16'h0700;
   localparam word_type SCROLL_BLANK = 16'h0C00;
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0A;

endpackage

`default_nettype wire

/* sv/tcw_vram.sv */
// Video word memory: one write port, one read port with registered read data.
// Depends on tcw_pkg for the word type.
`default_nettype none

module tcw_vram #(
   parameter int DEPTH = tcw_pkg::VIDEO_WORDS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire                  clock,
   input  wire                  wr_en,
   input  wire [AW-1:0]         wr_addr,
   input  tcw_pkg::word_type    wr_data,
   input  wire [AW-1:0]         rd_addr,
   output tcw_pkg::word_type    rd_data
);

   tcw_pkg::word_type mem [DEPTH];
   tcw_pkg::word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/text_console_writer.sv */
// Text console writer. Each item passes EXEC and then DONE; a newline or a line end adds
// NEWLINE (and a scroll on the bottom row), a set position adds SETPOS and SETLINE. A new
// item is taken only in IDLE or once the last result can leave DONE. A scroll blanks the new
// bottom line; a wrapping scroll first copies the lower SCREEN_ROWS-1 lines of the screen to
// the base of memory. Reset is synchronous and starts a clearing pass that blanks the first
// SCREEN_ROWS*LINE_CHARS words (2000 by default) with req_stall high.
`default_nettype none

module text_console_writer #(
   parameter int VIDEO_WORDS = tcw_pkg::VIDEO_WORDS_DEF,
   parameter int LINE_CHARS  = tcw_pkg::LINE_CHARS_DEF,
   parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   // request channel
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire [tcw_pkg::OP_W-1:0]      req_op,
   input  wire [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  wire [tcw_pkg::ROW_W-1:0]     req_new_row,
   input  wire [tcw_pkg::COL_W-1:0]     req_new_column,
   input  wire [tcw_pkg::ADDR_W-1:0]    req_read_address,
   // response channel
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [tcw_pkg::WORD_W-1:0]   rsp_read_data,
   output logic [tcw_pkg::ADDR_W-1:0]   rsp_cursor_address,
   output logic [tcw_pkg::ADDR_W-1:0]   rsp_origin_address,
   output logic [tcw_pkg::ROW_W-1:0]    rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0]    rsp_cursor_column,
   output logic                         rsp_scrolled,
   // attribute register write
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire [tcw_pkg::ATTR_W-1:0]    csr_text_attribute
);

   // Geometry derived from the parameters.
   localparam int AW         = $clog2(VIDEO_WORDS);
   localparam int RW         = $clog2(SCREEN_ROWS);
   localparam int CW         = $clog2(LINE_CHARS);
   localparam int SCREEN     = SCREEN_ROWS * LINE_CHARS;
   localparam int COPY_WORDS = SCREEN - LINE_CHARS;
   localparam int CNTW       = $clog2(COPY_WORDS + 1);
   localparam int ADDR_OW    = tcw_pkg::ADDR_W;
   localparam int ROW_OW     = tcw_pkg::ROW_W;
   localparam int COL_OW     = tcw_pkg::COL_W;

   localparam logic [AW-1:0]   LC_A        = AW'(LINE_CHARS);
   localparam logic [AW-1:0]   SCREEN_LAST = AW'(SCREEN - 1);
   localparam logic [AW-1:0]   COPY_BASE   = AW'(COPY_WORDS);
   localparam logic [AW:0]     FIT_MAX     = (AW+1)'(VIDEO_WORDS - 1 - LINE_CHARS);
   localparam logic [AW:0]     VW_X        = (AW+1)'(VIDEO_WORDS);
   localparam logic [RW-1:0]   ROW_LAST    = RW'(SCREEN_ROWS - 1);
   localparam logic [CW-1:0]   COL_LAST    = CW'(LINE_CHARS - 1);
   localparam logic [CNTW-1:0] CNT_COPY    = CNTW'(COPY_WORDS);
   localparam logic [CNTW-1:0] CNT_BLANK   = CNTW'(LINE_CHARS - 1);

   // Sequencer states.
   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_EXEC    = 4'd2;
   localparam logic [3:0] ST_NEWLINE = 4'd3;
   localparam logic [3:0] ST_SETPOS  = 4'd4;
   localparam logic [3:0] ST_SETLINE = 4'd5;
   localparam logic [3:0] ST_SCROLL  = 4'd6;
   localparam logic [3:0] ST_COPY    = 4'd7;
   localparam logic [3:0] ST_BLANK   = 4'd8;
   localparam logic [3:0] ST_DONE    = 4'd9;

   // Control state.
   logic [3:0]      state_ff, state_in;
   logic [AW-1:0]   ptr_ff, ptr_in;            // clear, copy source and blank pointer
   logic [CNTW-1:0] cnt_ff, cnt_in;            // copy and blank word count
   logic            wpend_ff, wpend_in;        // copy write waits for read data
   logic [AW-1:0]   wdst_ff, wdst_in;          // copy destination of that write
   logic [RW-1:0]   row_ff, row_in;
   logic [CW-1:0]   col_ff, col_in;
   logic [AW-1:0]   origin_ff, origin_in;
   logic [AW-1:0]   line_ff, line_in;          // origin + row * LINE_CHARS, kept current
   logic [tcw_pkg::ATTR_W-1:0] attr_ff, attr_in;
   logic            scr_ff, scr_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [AW-1:0]                prod_ff, prod_in;
   tcw_pkg::op_type              item_op_ff, item_op_in;
   tcw_pkg::char_type            item_ch_ff, item_ch_in;
   logic [tcw_pkg::ROW_W-1:0]    item_row_ff, item_row_in;
   logic [tcw_pkg::COL_W-1:0]    item_col_ff, item_col_in;
   logic [tcw_pkg::ADDR_W-1:0]   item_ra_ff, item_ra_in;
   logic [tcw_pkg::WORD_W-1:0]   rsp_read_data_ff, rsp_read_data_in;
   logic [tcw_pkg::ADDR_W-1:0]   rsp_cursor_address_ff, rsp_cursor_address_in;
   logic [tcw_pkg::ADDR_W-1:0]   rsp_origin_address_ff, rsp_origin_address_in;
   logic [tcw_pkg::ROW_W-1:0]    rsp_cursor_row_ff, rsp_cursor_row_in;
   logic [tcw_pkg::COL_W-1:0]    rsp_cursor_column_ff, rsp_cursor_column_in;
   logic                         rsp_scrolled_ff, rsp_scrolled_in;

   // Datapath signals.
   logic              accept;
   logic              out_free;
   logic              load_rsp;
   logic [AW-1:0]     add_a, add_b;
   logic [AW:0]       add_sum;
   logic [AW-1:0]     org_step;
   logic [CW-1:0]     col_dec;
   logic [RW-1:0]     sat_row;
   logic [CW-1:0]     sat_col;
   logic [AW:0]       ra_ext, ra_fold;
   logic [AW-1:0]     ra_wrap;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   tcw_pkg::word_type wr_data;
   logic [AW-1:0]     rd_addr;
   tcw_pkg::word_type rd_data;

   // Video memory.
   tcw_vram #(
      .DEPTH (VIDEO_WORDS),
      .AW    (AW)
   ) u_vram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Handshakes: take an item when idle, or when the finished result can leave this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_DONE) && out_free));
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Shared address adder: cursor cell, line advance, set-position line base.
   assign add_sum  = {1'b0, add_a} + {1'b0, add_b};
   assign org_step = origin_ff + LC_A;
   assign col_dec  = col_ff - 1'b1;

   // Saturate the requested position to the screen.
   assign sat_row = (int'(item_row_ff) > SCREEN_ROWS - 1) ? ROW_LAST : RW'(item_row_ff);
   assign sat_col = (int'(item_col_ff) > LINE_CHARS - 1) ? COL_LAST : CW'(item_col_ff);

   // Wrap the read address into the memory; one fold is enough for a 13-bit address.
   assign ra_ext  = (AW+1)'(item_ra_ff);
   assign ra_fold = (ra_ext >= VW_X) ? (ra_ext - VW_X) : ra_ext;
   assign ra_wrap = ra_fold[AW-1:0];

   // Capture the item on accept.
   assign item_op_in  = accept ? req_op           : item_op_ff;
   assign item_ch_in  = accept ? req_char_code    : item_ch_ff;
   assign item_row_in = accept ? req_new_row      : item_row_ff;
   assign item_col_in = accept ? req_new_column   : item_col_ff;
   assign item_ra_in  = accept ? req_read_address : item_ra_ff;

   // Attribute register.
   assign attr_in = (csr_valid && csr_ready) ? csr_text_attribute : attr_ff;

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      cnt_in    = cnt_ff;
      wpend_in  = 1'b0;
      wdst_in   = wdst_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      origin_in = origin_ff;
      line_in   = line_ff;
      prod_in   = prod_ff;
      scr_in    = scr_ff;
      load_rsp  = 1'b0;
      add_a     = line_ff;
      add_b     = AW'(col_ff);
      wr_en     = 1'b0;
      wr_addr   = ptr_ff;
      wr_data   = tcw_pkg::BLANK_WORD;
      rd_addr   = ra_wrap;

      case (state_ff)
         ST_CLEAR: begin
            // Fill the first screen with blanks, one word a cycle.
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = tcw_pkg::BLANK_WORD;
            if (ptr_ff == SCREEN_LAST) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            scr_in   = 1'b0;
            state_in = ST_DONE;
            case (item_op_ff)
               tcw_pkg::OP_PUT: begin
                  if (item_ch_ff == tcw_pkg::CH_NEWLINE) begin
                     state_in = ST_NEWLINE;
                  end else if (item_ch_ff == tcw_pkg::CH_RETURN) begin
                     col_in = '0;
                  end else if (item_ch_ff == tcw_pkg::CH_BACKSPACE) begin
                     // Step back and blank the new cell; drop it at column 0.
                     if (col_ff != '0) begin
                        add_b   = AW'(col_dec);
                        wr_en   = 1'b1;
                        wr_addr = add_sum[AW-1:0];
                        wr_data = tcw_pkg::BLANK_WORD;
                        col_in  = col_dec;
                     end
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = add_sum[AW-1:0];
                     wr_data = {attr_ff, item_ch_ff};
                     if (col_ff == COL_LAST) begin
                        col_in   = '0;
                        state_in = ST_NEWLINE;
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
               end
               tcw_pkg::OP_SETPOS: begin
                  row_in   = sat_row;
                  col_in   = sat_col;
                  state_in = ST_SETPOS;
               end
               default: begin
                  // Read: the memory reads the wrapped address; data is ready in DONE.
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_NEWLINE: begin
            if (row_ff == ROW_LAST) begin
               state_in = ST_SCROLL;
            end else begin
               add_b    = LC_A;
               row_in   = row_ff + 1'b1;
               line_in  = add_sum[AW-1:0];
               state_in = ST_DONE;
            end
         end
         ST_SETPOS: begin
            prod_in  = AW'(row_ff * LC_A);
            state_in = ST_SETLINE;
         end
         ST_SETLINE: begin
            add_a    = origin_ff;
            add_b    = prod_ff;
            line_in  = add_sum[AW-1:0];
            state_in = ST_DONE;
         end
         ST_SCROLL: begin
            // The bottom line moves down one line; check it still fits in memory.
            add_b  = LC_A;
            scr_in = 1'b1;
            cnt_in = '0;
            if (add_sum <= FIT_MAX) begin
               origin_in = org_step;
               line_in   = add_sum[AW-1:0];
               ptr_in    = add_sum[AW-1:0];
               state_in  = ST_BLANK;
            end else begin
               origin_in = '0;
               line_in   = COPY_BASE;
               ptr_in    = org_step;
               state_in  = ST_COPY;
            end
         end
         ST_COPY: begin
            // Read one source word a cycle; write it to the bottom of memory in the next cycle.
            rd_addr = ptr_ff;
            if (wpend_ff) begin
               wr_en   = 1'b1;
               wr_addr = wdst_ff;
               wr_data = rd_data;
            end
            if (cnt_ff != CNT_COPY) begin
               wpend_in = 1'b1;
               wdst_in  = AW'(cnt_ff);
               ptr_in   = ptr_ff + 1'b1;
               cnt_in   = cnt_ff + 1'b1;
            end else begin
               ptr_in   = COPY_BASE;
               cnt_in   = '0;
               state_in = ST_BLANK;
            end
         end
         ST_BLANK: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = tcw_pkg::SCROLL_BLANK;
            ptr_in  = ptr_ff + 1'b1;
            if (cnt_ff == CNT_BLANK) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            // Adder holds line + column here: the cursor address of the result.
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = accept ? ST_EXEC : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register: load when done, hold while stalled.
   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_read_data_in = !load_rsp ? rsp_read_data_ff :
                             (item_op_ff == tcw_pkg::OP_READ) ? rd_data : '0;
   assign rsp_cursor_address_in = load_rsp ? ADDR_OW'(add_sum[AW-1:0]) : rsp_cursor_address_ff;
   assign rsp_origin_address_in = load_rsp ? ADDR_OW'(origin_ff) : rsp_origin_address_ff;
   assign rsp_cursor_row_in     = load_rsp ? ROW_OW'(row_ff) : rsp_cursor_row_ff;
   assign rsp_cursor_column_in  = load_rsp ? COL_OW'(col_ff) : rsp_cursor_column_ff;
   assign rsp_scrolled_in       = load_rsp ? scr_ff : rsp_scrolled_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         cnt_ff       <= '0;
         wpend_ff     <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         origin_ff    <= '0;
         line_ff      <= '0;
         attr_ff      <= tcw_pkg::ATTR_RESET;
         scr_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         cnt_ff       <= cnt_in;
         wpend_ff     <= wpend_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         origin_ff    <= origin_in;
         line_ff      <= line_in;
         attr_ff      <= attr_in;
         scr_ff       <= scr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      wdst_ff               <= wdst_in;
      prod_ff               <= prod_in;
      item_op_ff            <= item_op_in;
      item_ch_ff            <= item_ch_in;
      item_row_ff           <= item_row_in;
      item_col_ff           <= item_col_in;
      item_ra_ff            <= item_ra_in;
      rsp_read_data_ff      <= rsp_read_data_in;
      rsp_cursor_address_ff <= rsp_cursor_address_in;
      rsp_origin_address_ff <= rsp_origin_address_in;
      rsp_cursor_row_ff     <= rsp_cursor_row_in;
      rsp_cursor_column_ff  <= rsp_cursor_column_in;
      rsp_scrolled_ff       <= rsp_scrolled_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rsp_read_data_ff;
   assign rsp_cursor_address = rsp_cursor_address_ff;
   assign rsp_origin_address = rsp_origin_address_ff;
   assign rsp_cursor_row     = rsp_cursor_row_ff;
   assign rsp_cursor_column  = rsp_cursor_column_ff;
   assign rsp_scrolled       = rsp_scrolled_ff;

endmodule

`default_nettype wire

/* sv/tcw_checker.sv */
// Port-level checker for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_assert.svh.
`default_nettype none

`include "text_console_writer_assert.svh"

module tcw_checker #(
   parameter int LINE_CHARS  = tcw_pkg::LINE_CHARS_DEF,
   parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF
) (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_stall,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input wire [tcw_pkg::WORD_W-1:0]    rsp_read_data,
   input wire [tcw_pkg::ADDR_W-1:0]    rsp_cursor_address,
   input wire [tcw_pkg::ADDR_W-1:0]    rsp_origin_address,
   input wire [tcw_pkg::ROW_W-1:0]     rsp_cursor_row,
   input wire [tcw_pkg::COL_W-1:0]     rsp_cursor_column,
   input wire                          rsp_scrolled
);

   localparam int ROW_OW = tcw_pkg::ROW_W;
   localparam logic [tcw_pkg::ROW_W-1:0] ROW_LAST = ROW_OW'(SCREEN_ROWS - 1);

   logic [tcw_pkg::WORD_W+2*tcw_pkg::ADDR_W+tcw_pkg::ROW_W+tcw_pkg::COL_W:0] rsp_bundle;

   assign rsp_bundle = {rsp_read_data, rsp_cursor_address, rsp_origin_address,
                        rsp_cursor_row, rsp_cursor_column, rsp_scrolled};

   // Hold a stalled result.
   `TCW_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_bundle))

   // Stay busy the cycle after taking an item.
   `TCW_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // A scroll always leaves the cursor on the bottom row.
   `TCW_ASSERT_IMPLY(a_scroll_bottom, rsp_valid && rsp_scrolled, rsp_cursor_row == ROW_LAST)

   // The column never reaches the line length.
   `TCW_ASSERT_IMPLY(a_column_range, rsp_valid, int'(rsp_cursor_column) < LINE_CHARS)

endmodule

bind text_console_writer tcw_checker #(
   .LINE_CHARS  (LINE_CHARS),
   .SCREEN_ROWS (SCREEN_ROWS)
) u_tcw_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_read_data      (rsp_read_data),
   .rsp_cursor_address (rsp_cursor_address),
   .rsp_origin_address (rsp_origin_address),
   .rsp_cursor_row     (rsp_cursor_row),
   .rsp_cursor_column  (rsp_cursor_column),
   .rsp_scrolled       (rsp_scrolled)
);

`default_nettype wire
